/* rtl/lba_shortcut_table_unit_defines.svh */
// assertion macros for the lba shortcut table unit
`ifndef LBA_SHORTCUT_TABLE_UNIT_DEFINES_SVH
`define LBA_SHORTCUT_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define LST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lst assertion failed");

// consequent must hold in the cycle after the antecedent
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lst assertion failed");

`else

`define LST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg
// shared constants, codes and controller/datapath types of the shortcut table
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int ADDRESS_COUNT = 65536;
    localparam int SLOT_COUNT    = 64;

    localparam int ADDR_W = $clog2(ADDRESS_COUNT);
    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);

    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(ADDRESS_COUNT - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(SLOT_COUNT - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(SLOT_COUNT);
    localparam logic [7:0]        SLOT_LIMIT = 8'(SLOT_COUNT);
    localparam logic [7:0]        NO_SLOT    = 8'hFF;

    localparam logic [2:0] MODE_ALLOC   = 3'd0;
    localparam logic [2:0] MODE_LINK    = 3'd1;
    localparam logic [2:0] MODE_UNLINK  = 3'd2;
    localparam logic [2:0] MODE_QUERY   = 3'd3;
    localparam logic [2:0] MODE_RELINK  = 3'd4;
    localparam logic [2:0] MODE_RELEASE = 3'd5;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_NO_FREE    = 3'd1;
    localparam logic [2:0] STAT_UNASSIGNED = 3'd2;
    localparam logic [2:0] STAT_NOT_BOUND  = 3'd3;
    localparam logic [2:0] STAT_NO_CHANGE  = 3'd4;

    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic commit;
    } lst_cmd_t;

    typedef struct packed {
        logic clear_done;
    } lst_sts_t;

endpackage

/* rtl/lst_if.sv */
// ----------------------------------------------------------------------------
// lst_if
// request and response channels of the shortcut table, valid/ready handshake
// ----------------------------------------------------------------------------
interface lst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] run_tag;
    logic [7:0]  slot;
    logic [15:0] lba;

    modport source (output valid, output mode, output run_tag, output slot,
                    output lba, input ready);
    modport sink   (input valid, input mode, input run_tag, input slot,
                    input lba, output ready);
endinterface

interface lst_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot_out;
    logic [15:0] run_tag_out;
    logic [31:0] link_count;
    logic [31:0] unlink_count;

    modport source (output valid, output status, output slot_out, output run_tag_out,
                    output link_count, output unlink_count, input ready);
    modport sink   (input valid, input status, input slot_out, input run_tag_out,
                    input link_count, input unlink_count, output ready);
endinterface

/* rtl/lst_ctrl.sv */
// ----------------------------------------------------------------------------
// lst_ctrl
// sequencer: map clearing pass, request accept, lookup, execute and response
// ----------------------------------------------------------------------------
`include "lba_shortcut_table_unit_defines.svh"

module lst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lst_pkg::lst_cmd_t cmd,
    input  lst_pkg::lst_sts_t sts
);
    import lst_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_EXEC   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // wait here while the previous response is still unclaimed
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `LST_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, req_valid && req_ready, state_reg == ST_LOOKUP)
    `LST_ASSERT_SAME(a_commit_output_free, clk, rst_n, cmd.commit, !rsp_valid_reg || rsp_ready)
    `LST_ASSERT_NEXT(a_exec_holds_on_stall, clk, rst_n, (state_reg == ST_EXEC) && rsp_valid_reg && !rsp_ready, (state_reg == ST_EXEC) && rsp_valid_reg)
    `LST_ASSERT_SAME(a_no_response_clearing, clk, rst_n, state_reg == ST_CLEAR, !rsp_valid_reg && !req_ready)

endmodule

/* rtl/lst_datapath.sv */
// ----------------------------------------------------------------------------
// lst_datapath
// address map, free slot fifo, slot tables, operation decode and response regs
// ----------------------------------------------------------------------------
module lst_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  lst_pkg::lst_cmd_t cmd,
    output lst_pkg::lst_sts_t sts,
    input  logic [2:0]        mode,
    input  logic [15:0]       run_tag,
    input  logic [7:0]        slot,
    input  logic [15:0]       lba,
    output logic [2:0]        status,
    output logic [7:0]        slot_out,
    output logic [15:0]       run_tag_out,
    output logic [31:0]       link_count,
    output logic [31:0]       unlink_count
);
    import lst_pkg::*;

    // memories
    logic [7:0]  map_mem   [ADDRESS_COUNT];
    logic [7:0]  fifo_mem  [SLOT_COUNT];
    logic [15:0] run_mem   [SLOT_COUNT];
    logic [31:0] links_mem [SLOT_COUNT];
    logic [31:0] unl_mem   [SLOT_COUNT];

    // control state
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [SLOT_COUNT-1:0] bound_reg;
    logic [SLOT_COUNT-1:0] fifo_vld_reg;
    logic [SLOT_COUNT-1:0] links_vld_reg;
    logic [SLOT_COUNT-1:0] unl_vld_reg;

    // captured request and read data
    logic [2:0]  mode_reg;
    logic [15:0] tag_reg;
    logic [7:0]  slot_reg;
    logic [15:0] lba_reg;
    logic        lba_ok_reg;
    logic [7:0]  map_rd_reg;
    logic [7:0]  fifo_rd_reg;
    logic [15:0] run_rd_reg;
    logic [31:0] links_rd_reg;
    logic [31:0] unl_rd_reg;
    logic [31:0] unl_old_rd_reg;

    // response registers
    logic [2:0]  status_reg;
    logic [7:0]  slot_out_reg;
    logic [15:0] run_out_reg;
    logic [31:0] links_out_reg;
    logic [31:0] unl_out_reg;

    logic [7:0]        tgt;
    logic [IDX_W-1:0]  tidx;
    logic [IDX_W-1:0]  sidx;
    logic [IDX_W-1:0]  oidx;
    logic [IDX_W-1:0]  aidx;
    logic              s_bound;
    logic              o_bound;
    logic              unassigned;
    logic [31:0]       links_inc;
    logic [31:0]       unl_inc;
    logic [31:0]       unl_old_inc;

    logic [2:0]        st;
    logic [7:0]        sl;
    logic [15:0]       run_o;
    logic [31:0]       lc_o;
    logic [31:0]       uc_o;
    logic              map_upd;
    logic [7:0]        map_wval;
    logic              links_we;
    logic              unl_we;
    logic [IDX_W-1:0]  unl_widx;
    logic [31:0]       unl_wval;
    logic              do_bind;
    logic              do_pop;
    logic              do_release;

    logic              map_we;
    logic [ADDR_W-1:0] map_waddr;
    logic [7:0]        map_wdata;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    assign sts.clear_done = (clr_cnt_reg == ADDR_LAST);

    // slot whose table entries answer the request
    assign tgt  = (mode_reg == MODE_ALLOC) ? fifo_rd_reg :
                  (mode_reg == MODE_QUERY) ? map_rd_reg  : slot_reg;
    assign tidx = tgt[IDX_W-1:0];
    assign sidx = slot_reg[IDX_W-1:0];
    assign oidx = map_rd_reg[IDX_W-1:0];
    assign aidx = fifo_rd_reg[IDX_W-1:0];

    assign s_bound    = (slot_reg < SLOT_LIMIT) && bound_reg[sidx];
    assign o_bound    = (map_rd_reg < SLOT_LIMIT) && bound_reg[oidx];
    assign unassigned = !lba_ok_reg || (map_rd_reg == NO_SLOT);

    assign links_inc   = sat_inc(links_rd_reg);
    assign unl_inc     = sat_inc(unl_rd_reg);
    assign unl_old_inc = sat_inc(unl_old_rd_reg);

    always_comb
    begin
        st         = STAT_NO_CHANGE;
        sl         = NO_SLOT;
        run_o      = '0;
        lc_o       = '0;
        uc_o       = '0;
        map_upd    = 1'b0;
        map_wval   = NO_SLOT;
        links_we   = 1'b0;
        unl_we     = 1'b0;
        unl_widx   = sidx;
        unl_wval   = unl_inc;
        do_bind    = 1'b0;
        do_pop     = 1'b0;
        do_release = 1'b0;
        unique case (mode_reg)
            MODE_ALLOC:
            begin
                if (fill_reg == '0)
                begin
                    st = STAT_NO_FREE;
                end
                else
                begin
                    do_pop = 1'b1;
                    if (fifo_rd_reg < SLOT_LIMIT)
                    begin
                        st      = STAT_OK;
                        sl      = fifo_rd_reg;
                        run_o   = tag_reg;
                        lc_o    = links_rd_reg;
                        uc_o    = unl_rd_reg;
                        do_bind = 1'b1;
                    end
                    else
                    begin
                        st = STAT_NO_FREE;
                    end
                end
            end
            MODE_LINK:
            begin
                if (!lba_ok_reg)
                begin
                    st = STAT_UNASSIGNED;
                end
                else if (!s_bound)
                begin
                    st = STAT_NOT_BOUND;
                end
                else
                begin
                    st       = STAT_OK;
                    sl       = slot_reg;
                    run_o    = run_rd_reg;
                    lc_o     = links_inc;
                    uc_o     = unl_rd_reg;
                    links_we = 1'b1;
                    map_upd  = 1'b1;
                    map_wval = slot_reg;
                end
            end
            MODE_UNLINK:
            begin
                if (unassigned)
                begin
                    st = STAT_UNASSIGNED;
                end
                else if (!s_bound)
                begin
                    st = STAT_NOT_BOUND;
                end
                else
                begin
                    st       = STAT_OK;
                    sl       = slot_reg;
                    run_o    = run_rd_reg;
                    lc_o     = links_rd_reg;
                    uc_o     = unl_inc;
                    unl_we   = 1'b1;
                    map_upd  = 1'b1;
                    map_wval = NO_SLOT;
                end
            end
            MODE_QUERY:
            begin
                if (unassigned)
                begin
                    st = STAT_UNASSIGNED;
                end
                else if (!o_bound)
                begin
                    st = STAT_NOT_BOUND;
                end
                else
                begin
                    st    = STAT_OK;
                    sl    = map_rd_reg;
                    run_o = run_rd_reg;
                    lc_o  = links_rd_reg;
                    uc_o  = unl_rd_reg;
                end
            end
            MODE_RELINK:
            begin
                if (unassigned)
                begin
                    st = STAT_UNASSIGNED;
                end
                else if (!o_bound || !s_bound)
                begin
                    st = STAT_NOT_BOUND;
                end
                else if (map_rd_reg == slot_reg)
                begin
                    st    = STAT_NO_CHANGE;
                    sl    = slot_reg;
                    run_o = run_rd_reg;
                    lc_o  = links_rd_reg;
                    uc_o  = unl_rd_reg;
                end
                else
                begin
                    // old slot counts an unlink, new slot counts a link
                    st       = STAT_OK;
                    sl       = slot_reg;
                    run_o    = run_rd_reg;
                    lc_o     = links_inc;
                    uc_o     = unl_rd_reg;
                    links_we = 1'b1;
                    unl_we   = 1'b1;
                    unl_widx = oidx;
                    unl_wval = unl_old_inc;
                    map_upd  = 1'b1;
                    map_wval = slot_reg;
                end
            end
            MODE_RELEASE:
            begin
                if (!s_bound || (fill_reg >= FILL_FULL))
                begin
                    st = STAT_NOT_BOUND;
                end
                else
                begin
                    st         = STAT_OK;
                    sl         = slot_reg;
                    do_release = 1'b1;
                end
            end
            default:
            begin
                st = STAT_NO_CHANGE;
            end
        endcase
    end

    assign map_we    = cmd.clear || (cmd.commit && map_upd);
    assign map_waddr = cmd.clear ? clr_cnt_reg : ADDR_W'(lba_reg);
    assign map_wdata = cmd.clear ? NO_SLOT : map_wval;

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.commit && do_bind)
        begin
            run_mem[aidx] <= tag_reg;
        end
        if (cmd.commit && links_we)
        begin
            links_mem[sidx] <= links_inc;
        end
        if (cmd.commit && unl_we)
        begin
            unl_mem[unl_widx] <= unl_wval;
        end
        if (cmd.commit && do_release)
        begin
            fifo_mem[tail_reg] <= slot_reg;
        end

        if (cmd.capture)
        begin
            mode_reg    <= mode;
            tag_reg     <= run_tag;
            slot_reg    <= slot;
            lba_reg     <= lba;
            lba_ok_reg  <= ({16'd0, lba} < 32'(ADDRESS_COUNT));
            map_rd_reg  <= map_mem[ADDR_W'(lba)];
            // untouched fifo entries hold no valid contents; their own index is read instead
            fifo_rd_reg <= fifo_vld_reg[head_reg] ? fifo_mem[head_reg] : 8'(head_reg);
        end

        if (cmd.lookup)
        begin
            run_rd_reg     <= run_mem[tidx];
            links_rd_reg   <= links_vld_reg[tidx] ? links_mem[tidx] : 32'd0;
            unl_rd_reg     <= unl_vld_reg[tidx] ? unl_mem[tidx] : 32'd0;
            unl_old_rd_reg <= unl_vld_reg[oidx] ? unl_mem[oidx] : 32'd0;
        end

        if (cmd.commit)
        begin
            status_reg    <= st;
            slot_out_reg  <= sl;
            run_out_reg   <= run_o;
            links_out_reg <= lc_o;
            unl_out_reg   <= uc_o;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= FILL_FULL;
            bound_reg     <= '0;
            fifo_vld_reg  <= '0;
            links_vld_reg <= '0;
            unl_vld_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (do_pop)
                begin
                    head_reg <= (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                    fill_reg <= fill_reg - 1'b1;
                end
                if (do_bind)
                begin
                    bound_reg[aidx] <= 1'b1;
                end
                if (links_we)
                begin
                    links_vld_reg[sidx] <= 1'b1;
                end
                if (unl_we)
                begin
                    unl_vld_reg[unl_widx] <= 1'b1;
                end
                if (do_release)
                begin
                    bound_reg[sidx]        <= 1'b0;
                    links_vld_reg[sidx]    <= 1'b0;
                    unl_vld_reg[sidx]      <= 1'b0;
                    fifo_vld_reg[tail_reg] <= 1'b1;
                    tail_reg <= (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    assign status       = status_reg;
    assign slot_out     = slot_out_reg;
    assign run_tag_out  = run_out_reg;
    assign link_count   = links_out_reg;
    assign unlink_count = unl_out_reg;

endmodule

/* rtl/lba_shortcut_table_unit.sv */
// ----------------------------------------------------------------------------
// lba_shortcut_table_unit
// shortcut table mapping logical block addresses to slots, with a free list
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   mode, run_tag, slot, lba
//   rsp      out  valid/ready   status, slot_out, run_tag_out, link_count,
//                               unlink_count
//
// a request passes accept, with the map and free list read, a lookup
// cycle on the slot tables, then an execute cycle that writes back and
// loads the response register; the slot-table read in lookup waits on
// the registered map and free list read. no request is taken until the
// last one has executed. after reset the map is swept to unassigned,
// req.ready low. a response waiting on rsp.ready does not block the
// next accept; the execute cycle holds until the response register frees up.
// ----------------------------------------------------------------------------
module lba_shortcut_table_unit (
    input  logic clk,
    input  logic rst_n,
    lst_req_if.sink   req,
    lst_rsp_if.source rsp
);
    import lst_pkg::*;

    lst_cmd_t cmd;
    lst_sts_t sts;

    lst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (req.mode),
        .run_tag      (req.run_tag),
        .slot         (req.slot),
        .lba          (req.lba),
        .status       (rsp.status),
        .slot_out     (rsp.slot_out),
        .run_tag_out  (rsp.run_tag_out),
        .link_count   (rsp.link_count),
        .unlink_count (rsp.unlink_count)
    );

endmodule

/* dv/tb_lba_shortcut_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lba_shortcut_table_unit
// self-checking bench for the lba shortcut table: a tracker class mirrors the
// address map, slot tables and free list, predicts every response and checks
// it field by field, while the request side sends bursts and the response
// side stalls on its own pattern
// ----------------------------------------------------------------------------
module tb_lba_shortcut_table_unit;
    import lst_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int ITEM_TARGET  = 1300;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int POOL_SIZE    = 24;
    localparam int ANSWER_DEPTH = 8;

    // modes with no operation behind them
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam logic [2:0] MODE_ORDER [6] = '{MODE_ALLOC, MODE_LINK, MODE_UNLINK,
                                              MODE_QUERY, MODE_RELINK, MODE_RELEASE};

    typedef enum int {MIX_BALANCED, MIX_ALLOC_HEAVY, MIX_RELEASE_HEAVY} mix_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] run_tag;
        logic [7:0]  slot;
        logic [15:0] lba;
    } lst_request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_out;
        logic [15:0] run_tag_out;
        logic [31:0] link_count;
        logic [31:0] unlink_count;
    } lst_answer_t;

    class shortcut_table_tracker;
        logic [7:0]  addr_map [ADDRESS_COUNT];
        bit          bound [SLOT_COUNT];
        logic [15:0] run_of [SLOT_COUNT];
        logic [31:0] links [SLOT_COUNT];
        logic [31:0] unlinks [SLOT_COUNT];
        logic [7:0]  free_ring [SLOT_COUNT];
        int          free_head;
        int          free_tail;
        int          free_fill;
        lst_answer_t answer_ring [ANSWER_DEPTH];
        int          answer_head;
        int          answer_tail;
        int          answer_fill;
        int          mismatch_count;

        function new();
            foreach (addr_map[i])
            begin
                addr_map[i] = NO_SLOT;
            end
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                bound[i]     = 1'b0;
                run_of[i]    = '0;
                links[i]     = '0;
                unlinks[i]   = '0;
                free_ring[i] = 8'(i);
            end
            free_head      = 0;
            free_tail      = 0;
            free_fill      = SLOT_COUNT;
            answer_head    = 0;
            answer_tail    = 0;
            answer_fill    = 0;
            mismatch_count = 0;
        endfunction

        function int free_count();
            return free_fill;
        endfunction

        function int pending_count();
            return answer_fill;
        endfunction

        function bit is_bound(logic [7:0] s);
            return (int'(s) < SLOT_COUNT) && bound[s];
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function lst_answer_t compose(logic [2:0] st, logic [7:0] s);
            lst_answer_t a;
            a.status = st;
            if (int'(s) < SLOT_COUNT && st != STAT_NO_FREE && st != STAT_UNASSIGNED &&
                st != STAT_NOT_BOUND)
            begin
                a.slot_out     = s;
                a.run_tag_out  = bound[s] ? run_of[s] : 16'h0000;
                a.link_count   = links[s];
                a.unlink_count = unlinks[s];
            end
            else
            begin
                a.slot_out     = NO_SLOT;
                a.run_tag_out  = '0;
                a.link_count   = '0;
                a.unlink_count = '0;
            end
            return a;
        endfunction

        function lst_answer_t apply_request(lst_request_t r);
            logic [7:0] s;
            logic [7:0] old;
            bit         lba_ok;
            s      = r.slot;
            lba_ok = int'(r.lba) < ADDRESS_COUNT;
            old    = lba_ok ? addr_map[r.lba] : NO_SLOT;
            case (r.mode)
                MODE_ALLOC:
                begin
                    if (free_fill == 0)
                        return compose(STAT_NO_FREE, NO_SLOT);
                    s         = free_ring[free_head];
                    free_head = (free_head + 1) % SLOT_COUNT;
                    free_fill--;
                    bound[s]  = 1'b1;
                    run_of[s] = r.run_tag;
                    return compose(STAT_OK, s);
                end
                MODE_LINK:
                begin
                    if (!lba_ok)
                        return compose(STAT_UNASSIGNED, NO_SLOT);
                    if (!is_bound(s))
                        return compose(STAT_NOT_BOUND, NO_SLOT);
                    links[s]         = bump(links[s]);
                    addr_map[r.lba]  = s;
                    return compose(STAT_OK, s);
                end
                MODE_UNLINK:
                begin
                    if (old == NO_SLOT)
                        return compose(STAT_UNASSIGNED, NO_SLOT);
                    if (!is_bound(s))
                        return compose(STAT_NOT_BOUND, NO_SLOT);
                    // counts go to the slot named in the request, not the mapped one
                    unlinks[s]       = bump(unlinks[s]);
                    addr_map[r.lba]  = NO_SLOT;
                    return compose(STAT_OK, s);
                end
                MODE_QUERY:
                begin
                    if (old == NO_SLOT)
                        return compose(STAT_UNASSIGNED, NO_SLOT);
                    if (!is_bound(old))
                        return compose(STAT_NOT_BOUND, NO_SLOT);
                    return compose(STAT_OK, old);
                end
                MODE_RELINK:
                begin
                    if (old == NO_SLOT)
                        return compose(STAT_UNASSIGNED, NO_SLOT);
                    if (!is_bound(old) || !is_bound(s))
                        return compose(STAT_NOT_BOUND, NO_SLOT);
                    if (old == s)
                        return compose(STAT_NO_CHANGE, s);
                    unlinks[old]     = bump(unlinks[old]);
                    links[s]         = bump(links[s]);
                    addr_map[r.lba]  = s;
                    return compose(STAT_OK, s);
                end
                MODE_RELEASE:
                begin
                    if (!is_bound(s) || free_fill >= SLOT_COUNT)
                        return compose(STAT_NOT_BOUND, NO_SLOT);
                    // map entries naming the slot stay behind
                    links[s]   = '0;
                    unlinks[s] = '0;
                    bound[s]   = 1'b0;
                    free_ring[free_tail] = s;
                    free_tail  = (free_tail + 1) % SLOT_COUNT;
                    free_fill++;
                    return compose(STAT_OK, s);
                end
                default:
                    return compose(STAT_NO_CHANGE, NO_SLOT);
            endcase
        endfunction

        function void note_request(lst_request_t r);
            if (answer_fill >= ANSWER_DEPTH)
            begin
                mismatch_count++;
                $display("[%0t] too many transactions in flight", $time);
                return;
            end
            answer_ring[answer_tail] = apply_request(r);
            answer_tail = (answer_tail + 1) % ANSWER_DEPTH;
            answer_fill++;
        endfunction

        function logic [7:0] any_bound_slot();
            logic [7:0] held [SLOT_COUNT];
            int         held_count;
            held_count = 0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (bound[i])
                begin
                    held[held_count] = 8'(i);
                    held_count++;
                end
            end
            if (held_count == 0)
                return NO_SLOT;
            return held[$urandom_range(0, held_count - 1)];
        endfunction

        function void report_field(string field, logic [31:0] want, logic [31:0] got);
            mismatch_count++;
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_answer(lst_answer_t got);
            lst_answer_t want;
            if (answer_fill == 0)
            begin
                mismatch_count++;
                $display("[%0t] response with nothing expected: status %0d slot %0d",
                         $time, got.status, got.slot_out);
                return;
            end
            want        = answer_ring[answer_head];
            answer_head = (answer_head + 1) % ANSWER_DEPTH;
            answer_fill--;
            if (got.status !== want.status)
                report_field("status", want.status, got.status);
            if (got.slot_out !== want.slot_out)
                report_field("slot_out", want.slot_out, got.slot_out);
            if (got.run_tag_out !== want.run_tag_out)
                report_field("run_tag_out", want.run_tag_out, got.run_tag_out);
            if (got.link_count !== want.link_count)
                report_field("link_count", want.link_count, got.link_count);
            if (got.unlink_count !== want.unlink_count)
                report_field("unlink_count", want.unlink_count, got.unlink_count);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lst_req_if req_ch ();
    lst_rsp_if rsp_ch ();

    lba_shortcut_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    shortcut_table_tracker tracker = new();

    int          cycle_count;
    int          items_sent;
    int          burst_left;
    bit          random_started;
    bit          long_hold_done;
    logic [15:0] lba_pool [POOL_SIZE];

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.mode    <= MODE_QUERY;
        req_ch.run_tag <= '0;
        req_ch.slot    <= '0;
        req_ch.lba     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_answer('{rsp_ch.status, rsp_ch.slot_out, rsp_ch.run_tag_out,
                                   rsp_ch.link_count, rsp_ch.unlink_count});
    end

    // response side: runs of random stall density, plus one long hold-off
    initial
    begin
        int run_len;
        int stall_pct;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (random_started && !long_hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            run_len = $urandom_range(4, 60);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (run_len)
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    function automatic lst_request_t req_of(logic [2:0] mode, logic [15:0] tag,
                                            logic [7:0] slot, logic [15:0] lba);
        lst_request_t r;
        r.mode    = mode;
        r.run_tag = tag;
        r.slot    = slot;
        r.lba     = lba;
        return r;
    endfunction

    function automatic lst_request_t shape_request(logic [2:0] mode);
        lst_request_t r;
        int           p;
        r.mode    = mode;
        r.run_tag = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 85)
        begin
            r.slot = tracker.any_bound_slot();
            if (r.slot == NO_SLOT)
                r.slot = 8'($urandom_range(0, SLOT_COUNT - 1));
        end
        else if (p < 95)
            r.slot = 8'($urandom_range(0, SLOT_COUNT - 1));
        else
            r.slot = 8'($urandom);
        if ($urandom_range(0, 99) < 80)
            r.lba = lba_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            r.lba = 16'($urandom);
        return r;
    endfunction

    function automatic lst_request_t make_request(mix_t mix);
        lst_request_t r;
        int           w [6];
        int           p;
        int           acc;
        logic [2:0]   m;
        case (mix)
            MIX_ALLOC_HEAVY:   w = '{40, 30, 5, 10, 10, 5};
            MIX_RELEASE_HEAVY: w = '{5, 20, 20, 20, 10, 25};
            default:           w = '{10, 30, 15, 20, 15, 10};
        endcase
        // a little pure noise, spare modes included
        if ($urandom_range(0, 99) < 5)
        begin
            r.mode    = 3'($urandom_range(0, 7));
            r.run_tag = 16'($urandom);
            r.slot    = 8'($urandom);
            r.lba     = 16'($urandom);
            return r;
        end
        p   = $urandom_range(0, 99);
        acc = 0;
        m   = MODE_RELEASE;
        for (int i = 0; i < 6; i++)
        begin
            acc += w[i];
            if (p < acc)
            begin
                m = MODE_ORDER[i];
                break;
            end
        end
        return shape_request(m);
    endfunction

    task automatic send_request(input lst_request_t r);
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= r.mode;
        req_ch.run_tag <= r.run_tag;
        req_ch.slot    <= r.slot;
        req_ch.lba     <= r.lba;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        tracker.note_request(r);
        items_sent++;
    endtask

    task automatic offer(input lst_request_t r);
        send_request(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_count() != 0) @(posedge clk);
    endtask

    initial
    begin
        bit   midway_paused;
        mix_t mix;
        int   episode_len;
        cycle_count    = 0;
        items_sent     = 0;
        random_started = 1'b0;
        long_hold_done = 1'b0;
        midway_paused  = 1'b0;
        burst_left     = $urandom_range(1, 30);
        lba_pool[0] = 16'h0000;
        lba_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            lba_pool[i] = 16'($urandom);

        wait (rst_n);
        @(posedge clk);

        // error answers on an empty table
        offer(req_of(MODE_QUERY, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_UNLINK, 16'hFFFF, 8'd0, 16'hFFFF));
        offer(req_of(MODE_RELINK, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_LINK, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_RELEASE, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_SPARE_A, 16'hFFFF, 8'd255, 16'hFFFF));
        offer(req_of(MODE_SPARE_B, 16'h0000, 8'd0, 16'h0000));
        // first two slots, then links, remaps and relinks
        offer(req_of(MODE_ALLOC, 16'hFFFF, 8'd255, 16'hFFFF));
        offer(req_of(MODE_ALLOC, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_LINK, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_LINK, 16'h0000, 8'd255, 16'hFFFF));
        offer(req_of(MODE_LINK, 16'h0000, 8'd1, 16'hFFFF));
        offer(req_of(MODE_QUERY, 16'h0000, 8'd0, 16'hFFFF));
        offer(req_of(MODE_RELINK, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_RELINK, 16'h0000, 8'd1, 16'h0000));
        offer(req_of(MODE_LINK, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_UNLINK, 16'h0000, 8'd1, 16'h0000));
        offer(req_of(MODE_RELINK, 16'h0000, 8'd200, 16'hFFFF));
        // release leaves a stale map entry behind
        offer(req_of(MODE_RELEASE, 16'h0000, 8'd1, 16'h0000));
        offer(req_of(MODE_QUERY, 16'h0000, 8'd0, 16'hFFFF));
        offer(req_of(MODE_RELINK, 16'h0000, 8'd0, 16'hFFFF));
        offer(req_of(MODE_UNLINK, 16'h0000, 8'd0, 16'hFFFF));
        offer(req_of(MODE_RELEASE, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_RELEASE, 16'h0000, 8'd0, 16'h0000));
        offer(req_of(MODE_RELEASE, 16'h0000, 8'd255, 16'h0000));
        pause_until_drained();

        random_started = 1'b1;

        // empty the free list, then ask for more
        while (tracker.free_count() > 0)
        begin
            offer(shape_request(MODE_ALLOC));
            if ($urandom_range(0, 1) == 1)
                offer(shape_request(MODE_LINK));
        end
        offer(shape_request(MODE_ALLOC));
        offer(shape_request(MODE_ALLOC));

        while (items_sent < ITEM_TARGET)
        begin
            mix = mix_t'($urandom_range(0, 2));
            episode_len = $urandom_range(20, 80);
            repeat (episode_len)
                offer(make_request(mix));
            if (!midway_paused && items_sent > ITEM_TARGET / 2)
            begin
                pause_until_drained();
                midway_paused = 1'b1;
            end
        end

        req_ch.valid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatch_count == 0 && tracker.pending_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/lst_pkg.sv
rtl/lst_if.sv
rtl/lst_ctrl.sv
rtl/lst_datapath.sv
rtl/lba_shortcut_table_unit.sv
dv/tb_lba_shortcut_table_unit.sv
